>>> hdl/qcpg_pkg.sv
// ---------------------------------------------------------------------------
// qcpg_pkg
// Shared types and constants of the centred proxy quad geometry unit.
// ---------------------------------------------------------------------------
package qcpg_pkg;

  // register stages through one line-intersection unit
  localparam int CROSS_LAT = 41;
  // width of the divider working remainder
  localparam int DIV_W     = 104;
  localparam int NCORNER   = 4;
  localparam int NRESULT   = 5;

  localparam logic       REG_PRINCIPAL_X = 1'b0;
  localparam logic       REG_PRINCIPAL_Y = 1'b1;
  localparam logic [2:0] IDX_LAST        = 3'd4;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pt_t;

  typedef pt_t [NCORNER-1:0] quad_t;

endpackage

>>> hdl/qcpg_cross.sv
// ---------------------------------------------------------------------------
// qcpg_cross
// Pipelined intersection of lines p1p2 and p3p4: exact products, rounded
// and saturated quotient by a 33-stage restoring divider per coordinate.
// ---------------------------------------------------------------------------
module qcpg_cross
  import qcpg_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  pt_t  p1,
  input  pt_t  p2,
  input  pt_t  p3,
  input  pt_t  p4,
  output pt_t  res
);

  // stage A: differences
  logic signed [32:0] dx12_r, dy12_r, dx34_r, dy34_r;
  pt_t                a1_r, a2_r, a3_r, a4_r;
  // stage B: first products
  logic signed [65:0] md1_r, md2_r;
  logic signed [63:0] mpa_r, mpb_r, mqa_r, mqb_r;
  logic signed [32:0] b_dx12_r, b_dy12_r, b_dx34_r, b_dy34_r;
  // stage C: determinant and cross terms
  logic signed [66:0] d3_r;
  logic signed [64:0] pre_r, post_r;
  logic signed [32:0] c_dx12_r, c_dy12_r, c_dx34_r, c_dy34_r;
  // stage D: partial products
  logic signed [65:0] phx_r, plx_r, phy_r, ply_r, qhx_r, qlx_r, qhy_r, qly_r;
  logic signed [66:0] d4_r;
  // stage E: numerators
  logic signed [99:0] nx_r, ny_r;
  logic signed [66:0] d5_r;
  // stage F: magnitudes
  logic [DIV_W-1:0]   numx_r, numy_r;
  logic [68:0]        den_r;
  logic               fnegx_r, fnegy_r, fzero_r;

  logic [99:0]        anx, any;
  logic [66:0]        ad;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= p1;
      a2_r   <= p2;
      a3_r   <= p3;
      a4_r   <= p4;
      dx12_r <= 33'(p1.x) - 33'(p2.x);
      dy12_r <= 33'(p1.y) - 33'(p2.y);
      dx34_r <= 33'(p3.x) - 33'(p4.x);
      dy34_r <= 33'(p3.y) - 33'(p4.y);

      md1_r    <= dx12_r * dy34_r;
      md2_r    <= dy12_r * dx34_r;
      mpa_r    <= a1_r.x * a2_r.y;
      mpb_r    <= a1_r.y * a2_r.x;
      mqa_r    <= a3_r.x * a4_r.y;
      mqb_r    <= a3_r.y * a4_r.x;
      b_dx12_r <= dx12_r;
      b_dy12_r <= dy12_r;
      b_dx34_r <= dx34_r;
      b_dy34_r <= dy34_r;

      d3_r     <= 67'(md1_r) - 67'(md2_r);
      pre_r    <= 65'(mpa_r) - 65'(mpb_r);
      post_r   <= 65'(mqa_r) - 65'(mqb_r);
      c_dx12_r <= b_dx12_r;
      c_dy12_r <= b_dy12_r;
      c_dx34_r <= b_dx34_r;
      c_dy34_r <= b_dy34_r;

      // split the 65-bit terms into a signed high and unsigned low half
      phx_r <= $signed(pre_r[64:32]) * c_dx34_r;
      plx_r <= $signed({1'b0, pre_r[31:0]}) * c_dx34_r;
      phy_r <= $signed(pre_r[64:32]) * c_dy34_r;
      ply_r <= $signed({1'b0, pre_r[31:0]}) * c_dy34_r;
      qhx_r <= $signed(post_r[64:32]) * c_dx12_r;
      qlx_r <= $signed({1'b0, post_r[31:0]}) * c_dx12_r;
      qhy_r <= $signed(post_r[64:32]) * c_dy12_r;
      qly_r <= $signed({1'b0, post_r[31:0]}) * c_dy12_r;
      d4_r  <= d3_r;

      nx_r <= (100'(phx_r) <<< 32) + 100'(plx_r) - (100'(qhx_r) <<< 32) - 100'(qlx_r);
      ny_r <= (100'(phy_r) <<< 32) + 100'(ply_r) - (100'(qhy_r) <<< 32) - 100'(qly_r);
      d5_r <= d4_r;

      // round half away: (2|n| + |d|) / (2|d|)
      numx_r  <= (DIV_W'(anx) << 1) + DIV_W'(ad);
      numy_r  <= (DIV_W'(any) << 1) + DIV_W'(ad);
      den_r   <= 69'(ad) << 1;
      fnegx_r <= nx_r[99] ^ d5_r[66];
      fnegy_r <= ny_r[99] ^ d5_r[66];
      fzero_r <= (d5_r == '0);
    end
  end

  always_comb begin
    anx = nx_r[99] ? 100'(-nx_r) : 100'(nx_r);
    any = ny_r[99] ? 100'(-ny_r) : 100'(ny_r);
    ad  = d5_r[66] ? 67'(-d5_r) : 67'(d5_r);
  end

  // divider: index 0 is the overflow stage, index k+1 holds quotient bit 32-k
  logic [DIV_W-1:0] rx_r  [0:32];
  logic [DIV_W-1:0] ry_r  [0:32];
  logic [68:0]      dv_r  [0:32];
  logic [32:0]      qx_r  [0:33];
  logic [32:0]      qy_r  [0:33];
  logic             ovx_r [0:33];
  logic             ovy_r [0:33];
  logic             ngx_r [0:33];
  logic             ngy_r [0:33];
  logic             zr_r  [0:33];

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]  <= numx_r;
      ry_r[0]  <= numy_r;
      dv_r[0]  <= den_r;
      ovx_r[0] <= numx_r >= (DIV_W'(den_r) << 33);
      ovy_r[0] <= numy_r >= (DIV_W'(den_r) << 33);
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      ngx_r[0] <= fnegx_r;
      ngy_r[0] <= fnegy_r;
      zr_r[0]  <= fzero_r;
    end
  end

  for (genvar k = 0; k < 33; k++) begin : g_div
    logic [DIV_W-1:0] dsh;
    logic             gex, gey;
    assign dsh = DIV_W'(dv_r[k]) << (32 - k);
    assign gex = rx_r[k] >= dsh;
    assign gey = ry_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        qx_r[k+1]  <= {qx_r[k][31:0], gex};
        qy_r[k+1]  <= {qy_r[k][31:0], gey};
        ovx_r[k+1] <= ovx_r[k];
        ovy_r[k+1] <= ovy_r[k];
        ngx_r[k+1] <= ngx_r[k];
        ngy_r[k+1] <= ngy_r[k];
        zr_r[k+1]  <= zr_r[k];
      end
    end

    if (k < 32) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rx_r[k+1] <= gex ? rx_r[k] - dsh : rx_r[k];
          ry_r[k+1] <= gey ? ry_r[k] - dsh : ry_r[k];
          dv_r[k+1] <= dv_r[k];
        end
      end
    end
  end

  function automatic logic signed [31:0] sat_q(input logic [32:0] q, input logic ov,
                                               input logic neg);
    logic signed [31:0] v;
    if (neg) begin
      if (ov || q[32] || (q[31] && (q[30:0] != '0))) v = 32'sh8000_0000;
      else v = $signed(-q[31:0]);
    end else begin
      if (ov || q[32] || q[31]) v = 32'sh7fff_ffff;
      else v = $signed(q[31:0]);
    end
    return v;
  endfunction

  pt_t res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // parallel lines give the origin
      res_r.x <= zr_r[33] ? '0 : sat_q(qx_r[33], ovx_r[33], ngx_r[33]);
      res_r.y <= zr_r[33] ? '0 : sat_q(qy_r[33], ovy_r[33], ngy_r[33]);
    end
  end

  assign res = res_r;

endmodule

>>> hdl/quad_centered_proxy_geometry_unit.sv
// ---------------------------------------------------------------------------
// quad_centered_proxy_geometry_unit
// Corner ordering and chained line intersections giving centred proxy corners.
// ---------------------------------------------------------------------------
// One quadrilateral beat is taken per cycle, when not stalled, into a fixed
// pipeline: one ordering stage and three levels of intersection units of 41
// stages each. Each quadrilateral leaves as five result beats (u0, u1, u2,
// u3, then the diagonal crossing, tlast on the fifth), one per cycle while
// out_tready is high, so the output channel sets the sustained rate.
// Back-pressure stalls the whole pipeline in step; nothing is dropped.
// The principal point is read live and must only be written while idle.
module quad_centered_proxy_geometry_unit
  import qcpg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x, point_y
  output logic [63:0]  out_tdata,
  // point_index, corners_sorted
  output logic [3:0]   out_tuser,
  // last_point
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [31:0]  cfg_wdata
);

  localparam int L = CROSS_LAT;

  logic signed [31:0] px_r, py_r;
  pt_t                um;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PRINCIPAL_X: px_r <= $signed(cfg_wdata);
        REG_PRINCIPAL_Y: py_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign um = '{x: px_r, y: py_r};

  logic en;

  // ordering around the centroid
  quad_t              cin, slot, ord;
  logic signed [33:0] sx, sy;
  logic signed [34:0] ex, ey;
  logic [3:0]         tk;
  logic               fail, hit, lt, gt, dn, up;
  logic [1:0]         k;

  always_comb begin
    for (int i = 0; i < NCORNER; i++) begin
      cin[i].x = $signed(in_tdata[64*i +: 32]);
      cin[i].y = $signed(in_tdata[64*i+32 +: 32]);
    end
    sx = '0;
    sy = '0;
    for (int i = 0; i < NCORNER; i++) begin
      sx = sx + 34'(cin[i].x);
      sy = sy + 34'(cin[i].y);
    end
    tk   = '0;
    fail = 1'b0;
    slot = cin;
    ex   = '0;
    ey   = '0;
    k    = '0;
    hit  = 1'b0;
    lt   = 1'b0;
    gt   = 1'b0;
    dn   = 1'b0;
    up   = 1'b0;
    for (int i = 0; i < NCORNER; i++) begin
      ex  = (35'(cin[i].x) <<< 2) - 35'(sx);
      ey  = (35'(cin[i].y) <<< 2) - 35'(sy);
      lt  = ex[34];
      gt  = !ex[34] && (ex != '0);
      up  = ey[34];
      dn  = !ey[34] && (ey != '0);
      hit = 1'b1;
      if (lt && dn && !tk[0]) k = 2'd0;
      else if (gt && dn && !tk[1]) k = 2'd1;
      else if (gt && up && !tk[2]) k = 2'd2;
      else if (lt && up && !tk[3]) k = 2'd3;
      else hit = 1'b0;
      if (!fail) begin
        if (hit) begin
          slot[k] = cin[i];
          tk[k]   = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
    end
    ord = fail ? cin : slot;
  end

  // valid, flag and corner delay lines alongside the intersection levels
  logic  v_r  [0:3*L];
  logic  ds_r [0:3*L];
  quad_t dq_r [0:2*L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= !fail;
      dq_r[0] <= ord;
    end
  end

  for (genvar j = 1; j <= 3*L; j++) begin : g_dl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) ds_r[j] <= ds_r[j-1];
    end
    if (j <= 2*L) begin : g_q
      always_ff @(posedge clk) begin
        if (en) dq_r[j] <= dq_r[j-1];
      end
    end
  end

  pt_t om, w0, w1, wd0, wd1, wm, u0, u1, u2, u3;

  // level one: diagonal crossing and vanishing points
  qcpg_cross u_om (.clk, .en, .p1(dq_r[0][0]), .p2(dq_r[0][2]), .p3(dq_r[0][1]),
                   .p4(dq_r[0][3]), .res(om));
  qcpg_cross u_w0 (.clk, .en, .p1(dq_r[0][0]), .p2(dq_r[0][1]), .p3(dq_r[0][2]),
                   .p4(dq_r[0][3]), .res(w0));
  qcpg_cross u_w1 (.clk, .en, .p1(dq_r[0][0]), .p2(dq_r[0][3]), .p3(dq_r[0][1]),
                   .p4(dq_r[0][2]), .res(w1));

  // level two: diagonal vanishing points and the vanishing-line point
  qcpg_cross u_wd0 (.clk, .en, .p1(w0), .p2(w1), .p3(dq_r[L][0]), .p4(dq_r[L][2]),
                    .res(wd0));
  qcpg_cross u_wd1 (.clk, .en, .p1(w0), .p2(w1), .p3(dq_r[L][1]), .p4(dq_r[L][3]),
                    .res(wd1));
  qcpg_cross u_wm  (.clk, .en, .p1(w0), .p2(w1), .p3(um), .p4(om), .res(wm));

  // level three: centred proxy corners
  qcpg_cross u_u0 (.clk, .en, .p1(dq_r[2*L][0]), .p2(wm), .p3(um), .p4(wd0), .res(u0));
  qcpg_cross u_u1 (.clk, .en, .p1(dq_r[2*L][1]), .p2(wm), .p3(um), .p4(wd1), .res(u1));
  qcpg_cross u_u2 (.clk, .en, .p1(dq_r[2*L][2]), .p2(wm), .p3(um), .p4(wd0), .res(u2));
  qcpg_cross u_u3 (.clk, .en, .p1(dq_r[2*L][3]), .p2(wm), .p3(um), .p4(wd1), .res(u3));

  // hold the diagonal crossing for the two later levels
  pt_t om_d_r [1:2*L];

  always_ff @(posedge clk) begin
    if (en) om_d_r[1] <= om;
  end

  for (genvar j = 2; j <= 2*L; j++) begin : g_om
    always_ff @(posedge clk) begin
      if (en) om_d_r[j] <= om_d_r[j-1];
    end
  end

  // five-beat output serialiser
  pt_t        res_r [0:NRESULT-1];
  logic       sorted_r, busy_r;
  logic [2:0] idx_r;
  logic       ser_load, beat_done;
  pt_t        cur;

  assign beat_done = out_tvalid && out_tready;
  assign ser_load  = v_r[3*L] && (!busy_r || (beat_done && idx_r == IDX_LAST));
  assign en        = !v_r[3*L] || ser_load;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (beat_done) begin
      if (idx_r == IDX_LAST) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      res_r[0] <= u0;
      res_r[1] <= u1;
      res_r[2] <= u2;
      res_r[3] <= u3;
      res_r[4] <= om_d_r[2*L];
      sorted_r <= ds_r[3*L];
    end
  end

  assign cur        = res_r[idx_r];
  assign out_tvalid = busy_r;
  assign out_tdata  = {cur.y, cur.x};
  assign out_tuser  = {sorted_r, idx_r};
  assign out_tlast  = (idx_r == IDX_LAST);

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load |=> busy_r && idx_r == '0)
    else $error("serialiser did not start at the first beat");

  a_beats_continue: assert property (@(posedge clk) disable iff (!rst_n)
    beat_done && !out_tlast |=> out_tvalid)
    else $error("result run broke off before its last beat");

  a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[3*L] |-> in_tready)
    else $error("pipeline stalled with an empty tail stage");

endmodule

>>> tb/quad_centered_proxy_geometry_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// quad_centered_proxy_geometry_unit_tb
// Self-checking bench for the centred proxy quad geometry unit: a directed
// table of quadrilaterals, then random well-formed and noisy quads under
// several principal points and idle and stall patterns, each result beat compared
// against a bit-exact intersection chain computed here.
// ---------------------------------------------------------------------------
module quad_centered_proxy_geometry_unit_tb
  import qcpg_pkg::*;
();

  localparam int PIPE_LAT  = 3 * CROSS_LAT + 1;
  localparam int MAX_CYC   = 600000;
  localparam int HOLD_LEN  = 400;

  typedef struct {
    pt_t        p;
    logic [2:0] idx;
    logic       sorted;
    logic       last;
  } geo_res_t;

  typedef struct {
    quad_t q;
    bit    typed;   // expected points all (0,0)
    bit    sorted;
  } quad_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we;
  logic         cfg_idx;
  logic [31:0]  cfg_wdata;

  geo_res_t  pending_pts[$];
  quad_row_t dir_rows[$];
  int        errors;
  int        cycles;
  int        idle_pct;
  int        stall_pct;
  int        hold_req;
  logic signed [31:0] pp_x;
  logic signed [31:0] pp_y;

  quad_centered_proxy_geometry_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- intersection chain --------------------------------------------------

  function automatic logic signed [31:0] div_round_sat(logic signed [127:0] n,
                                                       logic signed [127:0] d);
    logic        neg;
    logic [127:0] an, ad, q;
    neg = n[127] ^ d[127];
    an  = n[127] ? -n : n;
    ad  = d[127] ? -d : d;
    q   = (2 * an + ad) / (2 * ad);
    if (neg) begin
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic pt_t line_cross(pt_t p1, pt_t p2, pt_t p3, pt_t p4);
    logic signed [127:0] dx12, dy12, dx34, dy34, det, pre, post, nx, ny;
    pt_t r;
    dx12 = longint'(p1.x) - longint'(p2.x);
    dy12 = longint'(p1.y) - longint'(p2.y);
    dx34 = longint'(p3.x) - longint'(p4.x);
    dy34 = longint'(p3.y) - longint'(p4.y);
    det  = dx12 * dy34 - dy12 * dx34;
    r.x  = '0;
    r.y  = '0;
    if (det == 0) return r;
    pre  = 128'(signed'(p1.x)) * p2.y - 128'(signed'(p1.y)) * p2.x;
    post = 128'(signed'(p3.x)) * p4.y - 128'(signed'(p3.y)) * p4.x;
    nx   = pre * dx34 - dx12 * post;
    ny   = pre * dy34 - dy12 * post;
    r.x  = div_round_sat(nx, det);
    r.y  = div_round_sat(ny, det);
    return r;
  endfunction

  // order into BL, BR, TR, TL; keep input order on failure
  function automatic bit sort_quadrants(inout quad_t q);
    quad_t  slot;
    bit [3:0] taken;
    longint sx, sy, ex, ey;
    int     k;
    sx = 0;
    sy = 0;
    taken = '0;
    slot = q;
    for (int i = 0; i < NCORNER; i++) begin
      sx += q[i].x;
      sy += q[i].y;
    end
    for (int i = 0; i < NCORNER; i++) begin
      ex = 4 * longint'(q[i].x) - sx;
      ey = 4 * longint'(q[i].y) - sy;
      if      (ex < 0 && ey > 0 && !taken[0]) k = 0;
      else if (ex > 0 && ey > 0 && !taken[1]) k = 1;
      else if (ex > 0 && ey < 0 && !taken[2]) k = 2;
      else if (ex < 0 && ey < 0 && !taken[3]) k = 3;
      else return 1'b0;
      slot[k]  = q[i];
      taken[k] = 1'b1;
    end
    q = slot;
    return 1'b1;
  endfunction

  task automatic predict_proxy(input quad_t quad);
    quad_t    q;
    bit       ok;
    pt_t      um, om, w0, w1, wd0, wd1, wm;
    pt_t      res[NRESULT];
    geo_res_t r;
    q    = quad;
    ok   = sort_quadrants(q);
    um.x = pp_x;
    um.y = pp_y;
    om  = line_cross(q[0], q[2], q[1], q[3]);
    w0  = line_cross(q[0], q[1], q[2], q[3]);
    w1  = line_cross(q[0], q[3], q[1], q[2]);
    wd0 = line_cross(w0, w1, q[0], q[2]);
    wd1 = line_cross(w0, w1, q[1], q[3]);
    wm  = line_cross(w0, w1, um, om);
    res[0] = line_cross(q[0], wm, um, wd0);
    res[1] = line_cross(q[1], wm, um, wd1);
    res[2] = line_cross(q[2], wm, um, wd0);
    res[3] = line_cross(q[3], wm, um, wd1);
    res[4] = om;
    for (int i = 0; i < NRESULT; i++) begin
      r.p      = res[i];
      r.idx    = 3'(i);
      r.sorted = ok;
      r.last   = (3'(i) == IDX_LAST);
      pending_pts.insert(pending_pts.size(), r);
    end
  endtask

  // ---- stimulus helpers ----------------------------------------------------

  function automatic quad_t mkq(int x0, int y0, int x1, int y1,
                                int x2, int y2, int x3, int y3);
    quad_t q;
    q[0].x = x0; q[0].y = y0;
    q[1].x = x1; q[1].y = y1;
    q[2].x = x2; q[2].y = y2;
    q[3].x = x3; q[3].y = y3;
    return q;
  endfunction

  task automatic add_row(input quad_t q, input bit typed, input bit sorted);
    quad_row_t row;
    row.q      = q;
    row.typed  = typed;
    row.sorted = sorted;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic int rnd_s(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic quad_t rand_quad();
    quad_t q;
    pt_t   t;
    int    cx, cy, sc, mode, j;
    mode = $urandom_range(99);
    if (mode < 10) begin
      for (int i = 0; i < NCORNER; i++) begin
        q[i].x = $urandom;
        q[i].y = $urandom;
      end
      return q;
    end
    if (mode < 16) begin
      // coarse grid: lots of axis hits and repeated classes
      for (int i = 0; i < NCORNER; i++) begin
        q[i].x = rnd_s(2) * 256;
        q[i].y = rnd_s(2) * 256;
      end
      return q;
    end
    sc = (mode < 26) ? (1 << 28) : (1 << $urandom_range(10, 20));
    cx = rnd_s(sc);
    cy = rnd_s(sc);
    q = mkq(cx - int'($urandom_range(sc)) - 1, cy + int'($urandom_range(sc)) + 1,
            cx + int'($urandom_range(sc)) + 1, cy + int'($urandom_range(sc)) + 1,
            cx + int'($urandom_range(sc)) + 1, cy - int'($urandom_range(sc)) - 1,
            cx - int'($urandom_range(sc)) - 1, cy - int'($urandom_range(sc)) - 1);
    if (mode < 60) begin
      for (int i = NCORNER - 1; i > 0; i--) begin
        j    = $urandom_range(i);
        t    = q[i];
        q[i] = q[j];
        q[j] = t;
      end
    end
    return q;
  endfunction

  // ---- drivers -------------------------------------------------------------

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_quad(input quad_t q, input bit typed, input bit sorted);
    bit       fire;
    geo_res_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk);
      fire = in_tready;
      @(posedge clk);
    end
    if (typed) begin
      for (int i = 0; i < NRESULT; i++) begin
        r.p.x = '0;
        r.p.y = '0;
        r.idx = 3'(i);
        r.sorted = sorted;
        r.last = (3'(i) == IDX_LAST);
        pending_pts.insert(pending_pts.size(), r);
      end
    end else begin
      predict_proxy(q);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
  endtask

  task automatic set_principal(input logic signed [31:0] x, input logic signed [31:0] y);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PRINCIPAL_X;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_idx   <= REG_PRINCIPAL_Y;
    cfg_wdata <= y;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pp_x = x;
    pp_y = y;
  endtask

  task automatic run_random(input int n, input int ipct, input int spct);
    idle_pct  = ipct;
    stall_pct = spct;
    for (int i = 0; i < n; i++) begin
      send_quad(rand_quad(), 1'b0, 1'b0);
      // pause mid-phase until everything has come back
      if (i == n / 2 && ipct != 0) drain_results();
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // checker: sample at the falling edge ahead of the edge that takes the beat
  always @(negedge clk) begin
    geo_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result beat data=%h user=%h last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        e = pending_pts.pop_front();
        if (out_tdata[31:0] !== e.p.x) begin
          $display("%0t: point_x expected %h actual %h", $time, e.p.x, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.p.y) begin
          $display("%0t: point_y expected %h actual %h", $time, e.p.y, out_tdata[63:32]);
          errors++;
        end
        if (out_tuser[2:0] !== e.idx) begin
          $display("%0t: point_index expected %0d actual %0d", $time, e.idx, out_tuser[2:0]);
          errors++;
        end
        if (out_tuser[3] !== e.sorted) begin
          $display("%0t: corners_sorted expected %b actual %b", $time, e.sorted, out_tuser[3]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: last_point expected %b actual %b", $time, e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("** quad_centered_proxy_geometry_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    errors    = 0;
    cycles    = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 0;
    pp_x      = '0;
    pp_y      = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_PRINCIPAL_X;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed rows expect every point at the origin
    add_row(mkq(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0);
    add_row(mkq(-256, 256, 256, 256, 256, -256, -256, -256), 1'b1, 1'b1);
    add_row(mkq(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
            1'b1, 1'b0);
    add_row(mkq(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000),
            1'b1, 1'b0);
    add_row(mkq(1280, 1280, 1280, 1280, 1280, 1280, 1280, 1280), 1'b1, 1'b0);
    // extremes of the field range
    add_row(mkq(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000),
            1'b0, 1'b0);
    add_row(mkq(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFF00, 32'h70000000,
                32'h6FFFFFFF, 32'h80000100, 32'h80000000, 32'h90000000),
            1'b0, 1'b0);
    add_row(mkq(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                32'h0F0F0F0F, 32'hF0F0F0F0, 32'hF0F0F0F0, 32'h0F0F0F0F),
            1'b0, 1'b0);
    // perspective quad, in order and in reverse order
    add_row(mkq(120*256, 400*256, 500*256, 420*256,
                480*256, 100*256, 110*256, 90*256), 1'b0, 1'b0);
    add_row(mkq(110*256, 90*256, 480*256, 100*256,
                500*256, 420*256, 120*256, 400*256), 1'b0, 1'b0);
    // trapezoid: one pair of sides parallel
    add_row(mkq(-2560, 1280, 2560, 1280, 1280, -1280, -1280, -1280), 1'b0, 1'b0);
    // corners on the centroid's axes
    add_row(mkq(0, 2560, 2560, 0, 0, -2560, -2560, 0), 1'b0, 1'b0);
    // two corners in the bottom-left class
    add_row(mkq(-2560, 2560, -2000, 2000, 2560, -2560, 2000, 1000), 1'b0, 1'b0);
    // nearly parallel sides: far vanishing points, saturation
    add_row(mkq(-256000, 1000, 256000, 1000, 256001, -1000, -256000, -1000),
            1'b0, 1'b0);
    add_row(mkq(-30000000, 1, 30000000, 2, 30000001, -1, -30000000, -2), 1'b0, 1'b0);
    // kite
    add_row(mkq(-2560, 512, 2560, 768, 256, -5120, -256, -256), 1'b0, 1'b0);
    foreach (dir_rows[i])
      send_quad(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].sorted);

    set_principal(320 * 256, 240 * 256);
    run_random(70, 0, 0);
    set_principal(32'sh7FFFFFFF, 32'sh80000000);
    run_random(70, 45, 0);
    set_principal(32'sh80000000, 32'sh7FFFFFFF);
    run_random(70, 0, 45);
    set_principal($urandom, $urandom);
    run_random(70, 29, 29);

    // hold the receiver off long enough to back the pipeline up
    set_principal(rnd_s(1 << 20), rnd_s(1 << 20));
    stall_pct = 0;
    idle_pct  = 0;
    hold_req  = HOLD_LEN;
    for (int i = 0; i < 130; i++) send_quad(rand_quad(), 1'b0, 1'b0);

    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2 * NRESULT) @(posedge clk);
    if (errors == 0) begin
      $display("** quad_centered_proxy_geometry_unit: PASSED **");
    end else begin
      $display("** quad_centered_proxy_geometry_unit: FAILED **");
    end
    $finish;
  end

endmodule
